FILE: hw/rtl/camera_center_pixel_calibrator_unit_assert.svh
// Assertion macros for the center pixel calibrator checker.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef CAMERA_CENTER_PIXEL_CALIBRATOR_UNIT_ASSERT_SVH
`define CAMERA_CENTER_PIXEL_CALIBRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CCPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define CCPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CCPC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ccpc_pkg.sv
package ccpc_pkg;

  // Config register indexes
  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_ROW_SKIP = 2'd1;
  localparam logic [1:0] CFG_COL_SKIP = 2'd2;

  // Mode codes (code 3 acts as check)
  localparam logic [1:0] MODE_CHECK = 2'd0;
  localparam logic [1:0] MODE_BLACK = 2'd1;
  localparam logic [1:0] MODE_WHITE = 2'd2;

  // Pixel class codes
  localparam logic [1:0] CLS_BLACK = 2'd0;
  localparam logic [1:0] CLS_WHITE = 2'd1;
  localparam logic [1:0] CLS_UNCAL = 2'd2;

  localparam logic [9:0] ROW_SKIP_RST = 10'd88;
  localparam logic [9:0] COL_SKIP_RST = 10'd72;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_ROWS   = 5'b00010,
    PH_HHIGH  = 5'b00100,
    PH_COLS   = 5'b01000,
    PH_SAMPLE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       vsync;
    logic       href;
    logic       pclk;
    logic [7:0] pixel_data;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_average;
    logic [1:0] pixel_class;
    logic [7:0] threshold_out;
  } out_t;

endpackage

FILE: hw/rtl/camera_center_pixel_calibrator_unit.sv
// Center pixel calibrator. Each transfer on the in_ channel is one snapshot of the
// camera pins (vsync, href, pclk, pixel bus) taken on one system clock; pins are
// edge-detected against the previous transfer. After a vsync falling edge the unit
// skips row_skip href falling edges, waits for href high, skips col_skip pclk
// falling edges, then sums PIXELS pixel samples taken on pclk rising edges and
// emits one result with the floored average. mode selects what the average does:
// check (classify against the threshold; class "not calibrated" while the threshold
// is zero), calibrate black (store as black level) or calibrate white (threshold
// becomes the mean of black and white). Config writes (cfg_ index 0 mode, 1
// row_skip, 2 col_skip) take effect at once; mode is read when a result forms.
// Rate: one input transfer per clock unless stalled. All processing for a snapshot
// happens in the cycle it is taken; a result appears on out_ the next cycle from
// the output register. in_ready drops only while that register holds a result
// not being taken, so the rate holds while the sink keeps up. The average is a
// reciprocal multiply of the sample sum, the one multiplier in the design.
module camera_center_pixel_calibrator_unit #(
  parameter int PIXELS = 5  // samples per measurement, 1..16
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  ccpc_pkg::in_t       in_data,

  output logic                out_valid,
  input  logic                out_ready,
  output ccpc_pkg::out_t      out_data,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data
);

  // Sum of PIXELS 8-bit samples never exceeds 256*PIXELS
  localparam int SUM_W  = 8 + $clog2(PIXELS);
  localparam int CNT_W  = $clog2(PIXELS + 1);
  // floor(x/PIXELS) == (x*RCP_M) >> RCP_SH, exact for x < 2**SUM_W
  localparam int RCP_SH = SUM_W + $clog2(PIXELS);
  localparam int RCP_M  = ((1 << RCP_SH) + PIXELS - 1) / PIXELS;
  localparam int PROD_W = SUM_W + RCP_SH + 1;

  // Config registers
  logic [1:0] mode_r;
  logic [9:0] row_skip_r;
  logic [9:0] col_skip_r;

  // Measurement state
  ccpc_pkg::phase_t   phase_r, phase_nxt;
  logic [9:0]         row_count_r, row_count_nxt;
  logic [9:0]         col_count_r, col_count_nxt;
  logic [CNT_W-1:0]   sample_count_r, sample_count_nxt;
  logic [SUM_W-1:0]   pixel_sum_r, pixel_sum_nxt;
  logic               prev_vsync_r, prev_href_r, prev_pclk_r;
  logic [7:0]         black_level_r, black_level_nxt;
  logic [7:0]         threshold_r, threshold_nxt;

  // Output register
  logic               out_valid_r;
  ccpc_pkg::out_t     out_data_r;

  logic               in_xfer;
  logic               v_fall, h_fall, p_fall, p_rise;
  logic [9:0]         row_inc, col_inc;
  logic [CNT_W-1:0]   cnt_inc;
  logic [SUM_W-1:0]   sum_add;
  logic [PROD_W-1:0]  avg_prod;
  logic [7:0]         avg;
  logic [8:0]         mid_sum;
  logic               res_fire;
  ccpc_pkg::out_t     res;

  assign cfg_ready = 1'b1;
  // Take a snapshot unless a finished result is stuck at the output
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Pin edges against the previous snapshot
  assign v_fall = prev_vsync_r && !in_data.vsync;
  assign h_fall = prev_href_r  && !in_data.href;
  assign p_fall = prev_pclk_r  && !in_data.pclk;
  assign p_rise = !prev_pclk_r && in_data.pclk;

  assign row_inc  = row_count_r + 10'd1;
  assign col_inc  = col_count_r + 10'd1;
  assign cnt_inc  = sample_count_r + CNT_W'(1);
  assign sum_add  = pixel_sum_r + SUM_W'(in_data.pixel_data);
  assign avg_prod = PROD_W'(sum_add) * PROD_W'(RCP_M);
  assign avg      = avg_prod[RCP_SH +: 8];
  assign mid_sum  = {1'b0, black_level_r} + {1'b0, avg};

  always_comb begin
    phase_nxt        = phase_r;
    row_count_nxt    = row_count_r;
    col_count_nxt    = col_count_r;
    sample_count_nxt = sample_count_r;
    pixel_sum_nxt    = pixel_sum_r;
    black_level_nxt  = black_level_r;
    threshold_nxt    = threshold_r;
    res_fire         = 1'b0;
    res              = '0;

    case (phase_r)
      ccpc_pkg::PH_IDLE: begin
        if (v_fall) begin
          row_count_nxt = '0;
          phase_nxt = (row_skip_r == 10'd0) ? ccpc_pkg::PH_HHIGH : ccpc_pkg::PH_ROWS;
        end
      end
      ccpc_pkg::PH_ROWS: begin
        if (h_fall) begin
          row_count_nxt = row_inc;
          if (row_inc >= row_skip_r) begin
            phase_nxt = ccpc_pkg::PH_HHIGH;
          end
        end
      end
      ccpc_pkg::PH_HHIGH: begin
        if (in_data.href) begin
          col_count_nxt = '0;
          if (col_skip_r == 10'd0) begin
            sample_count_nxt = '0;
            pixel_sum_nxt    = '0;
            phase_nxt        = ccpc_pkg::PH_SAMPLE;
          end else begin
            phase_nxt = ccpc_pkg::PH_COLS;
          end
        end
      end
      ccpc_pkg::PH_COLS: begin
        if (p_fall) begin
          col_count_nxt = col_inc;
          if (col_inc >= col_skip_r) begin
            sample_count_nxt = '0;
            pixel_sum_nxt    = '0;
            phase_nxt        = ccpc_pkg::PH_SAMPLE;
          end
        end
      end
      ccpc_pkg::PH_SAMPLE: begin
        if (p_rise) begin
          pixel_sum_nxt    = sum_add;
          sample_count_nxt = cnt_inc;
          if (cnt_inc >= CNT_W'(PIXELS)) begin
            res_fire          = 1'b1;
            phase_nxt         = ccpc_pkg::PH_IDLE;
            res.pixel_average = avg;
            res.pixel_class   = ccpc_pkg::CLS_BLACK;
            case (mode_r)
              ccpc_pkg::MODE_BLACK: begin
                black_level_nxt = avg;
              end
              ccpc_pkg::MODE_WHITE: begin
                threshold_nxt = mid_sum[8:1];
              end
              default: begin
                if (threshold_r == 8'd0) begin
                  res.pixel_class = ccpc_pkg::CLS_UNCAL;
                end else if (avg > threshold_r) begin
                  res.pixel_class = ccpc_pkg::CLS_WHITE;
                end
              end
            endcase
            res.threshold_out = threshold_nxt;
          end
        end
      end
      default: begin
        phase_nxt = ccpc_pkg::PH_IDLE;
      end
    endcase
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= ccpc_pkg::MODE_CHECK;
      row_skip_r <= ccpc_pkg::ROW_SKIP_RST;
      col_skip_r <= ccpc_pkg::COL_SKIP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccpc_pkg::CFG_MODE:     mode_r     <= cfg_data[1:0];
        ccpc_pkg::CFG_ROW_SKIP: row_skip_r <= cfg_data;
        ccpc_pkg::CFG_COL_SKIP: col_skip_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // State advances once per accepted snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ccpc_pkg::PH_IDLE;
      row_count_r    <= '0;
      col_count_r    <= '0;
      sample_count_r <= '0;
      pixel_sum_r    <= '0;
      prev_vsync_r   <= 1'b0;
      prev_href_r    <= 1'b0;
      prev_pclk_r    <= 1'b0;
      black_level_r  <= '0;
      threshold_r    <= '0;
    end else if (in_xfer) begin
      phase_r        <= phase_nxt;
      row_count_r    <= row_count_nxt;
      col_count_r    <= col_count_nxt;
      sample_count_r <= sample_count_nxt;
      pixel_sum_r    <= pixel_sum_nxt;
      prev_vsync_r   <= in_data.vsync;
      prev_href_r    <= in_data.href;
      prev_pclk_r    <= in_data.pclk;
      black_level_r  <= black_level_nxt;
      threshold_r    <= threshold_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_fire) begin
      out_data_r <= res;
    end
  end

endmodule

FILE: hw/rtl/ccpc_checker.sv
`include "camera_center_pixel_calibrator_unit_assert.svh"

module ccpc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ccpc_pkg::out_t out_data
);

  // Result must wait, unchanged, while the sink stalls
  `CCPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed or dropped")
  // No result straight out of reset
  `CCPC_ASSERT_RST(a_rst_quiet, !rst_n, !out_valid, "result valid after reset")
  // Input back-pressure only comes from a blocked result
  `CCPC_ASSERT_NOW(a_ready_cause, !in_ready, out_valid && !out_ready, "input stalled without output stall")
  // Not-calibrated class only with a zero threshold
  `CCPC_ASSERT_NOW(a_uncal_thr, out_valid && out_data.pixel_class == ccpc_pkg::CLS_UNCAL, out_data.threshold_out == 8'd0, "uncalibrated class with nonzero threshold")

endmodule

bind camera_center_pixel_calibrator_unit ccpc_checker u_ccpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/tb_camera_center_pixel_calibrator_unit.sv
`timescale 1ns / 100ps

module tb_camera_center_pixel_calibrator_unit;

  localparam int NUM_SAMPLES   = 5;       // PIXELS of the unit under test
  localparam int CLK_HALF      = 10;      // 20 ns period
  localparam int SETTLE_CYCLES = 4;       // margin after the registered result
  localparam int CYCLE_LIMIT   = 200000;  // far above the slowest legal run

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  ccpc_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ccpc_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = ccpc_pkg::CFG_MODE;
  logic [9:0]     cfg_data  = '0;

  camera_center_pixel_calibrator_unit #(.PIXELS(NUM_SAMPLES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calibrator mirror: register copies and measurement state, updated once per
  // accepted snapshot transfer and once per accepted register write.
  // ---------------------------------------------------------------------------
  logic [1:0]       cal_mode      = ccpc_pkg::MODE_CHECK;
  logic [9:0]       skip_rows     = ccpc_pkg::ROW_SKIP_RST;
  logic [9:0]       skip_cols     = ccpc_pkg::COL_SKIP_RST;
  ccpc_pkg::phase_t meter_phase   = ccpc_pkg::PH_IDLE;
  logic [9:0]       rows_seen     = '0;
  logic [9:0]       cols_seen     = '0;
  logic [4:0]       samples_taken = '0;
  logic [11:0]      sample_sum    = '0;
  logic             last_vs       = 1'b0;
  logic             last_hr       = 1'b0;
  logic             last_pc       = 1'b0;
  logic [7:0]       black_ref     = '0;
  logic [7:0]       threshold_ref = '0;   // zero reads as "not calibrated"

  ccpc_pkg::out_t expected_readings[$];
  int unsigned readings_predicted = 0;
  int unsigned snapshots_sent     = 0;
  int unsigned mismatches         = 0;
  int unsigned cycle_count        = 0;
  int          tx_idle_pct        = 0;
  int          rx_stall_pct       = 0;

  // Advances the mirror by one pin snapshot; returns 1 when a measurement
  // completes, with the reading the unit must produce.
  function automatic bit measure_snapshot(input ccpc_pkg::in_t snap,
                                          output ccpc_pkg::out_t reading);
    logic       v_fall, h_fall, p_fall, p_rise;
    logic [7:0] avg;
    bit         done;
    v_fall  = last_vs & ~snap.vsync;
    h_fall  = last_hr & ~snap.href;
    p_fall  = last_pc & ~snap.pclk;
    p_rise  = ~last_pc & snap.pclk;
    done    = 1'b0;
    reading = '0;
    case (meter_phase)
      ccpc_pkg::PH_IDLE: if (v_fall) begin
        rows_seen   = '0;
        meter_phase = (skip_rows == 0) ? ccpc_pkg::PH_HHIGH : ccpc_pkg::PH_ROWS;
      end
      ccpc_pkg::PH_ROWS: if (h_fall) begin
        rows_seen = rows_seen + 1'b1;
        // >= so that a skip lowered below the count ends on the next edge
        if (rows_seen >= skip_rows) meter_phase = ccpc_pkg::PH_HHIGH;
      end
      ccpc_pkg::PH_HHIGH: if (snap.href) begin
        cols_seen = '0;
        if (skip_cols == 0) begin
          samples_taken = '0;
          sample_sum    = '0;
          meter_phase   = ccpc_pkg::PH_SAMPLE;
        end else begin
          meter_phase = ccpc_pkg::PH_COLS;
        end
      end
      ccpc_pkg::PH_COLS: if (p_fall) begin
        cols_seen = cols_seen + 1'b1;
        if (cols_seen >= skip_cols) begin
          samples_taken = '0;
          sample_sum    = '0;
          meter_phase   = ccpc_pkg::PH_SAMPLE;
        end
      end
      ccpc_pkg::PH_SAMPLE: if (p_rise) begin
        sample_sum    = sample_sum + snap.pixel_data;
        samples_taken = samples_taken + 1'b1;
        if (samples_taken >= NUM_SAMPLES) begin
          avg                   = 8'(sample_sum / NUM_SAMPLES);
          reading.pixel_average = avg;
          reading.pixel_class   = ccpc_pkg::CLS_BLACK;   // calibrate modes report black
          // mode is taken as it stands when the measurement closes
          case (cal_mode)
            ccpc_pkg::MODE_BLACK: black_ref = avg;
            ccpc_pkg::MODE_WHITE: threshold_ref = 8'((int'(black_ref) + int'(avg)) / 2);
            default: begin   // check, and the unused code that acts as check
              if (threshold_ref == 0) reading.pixel_class = ccpc_pkg::CLS_UNCAL;
              else if (avg > threshold_ref) reading.pixel_class = ccpc_pkg::CLS_WHITE;
            end
          endcase
          reading.threshold_out = threshold_ref;
          meter_phase           = ccpc_pkg::PH_IDLE;
          done                  = 1'b1;
        end
      end
      default: meter_phase = ccpc_pkg::PH_IDLE;
    endcase
    last_vs = snap.vsync;
    last_hr = snap.href;
    last_pc = snap.pclk;
    return done;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and in-order compare against the mirror.
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_stall_pct);

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t MISMATCH %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  ccpc_pkg::out_t oldest_reading;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t MISMATCH unexpected reading: expected none, actual avg %0d class %0d thr %0d",
                 $time, out_data.pixel_average, out_data.pixel_class, out_data.threshold_out);
        mismatches++;
      end else begin
        oldest_reading = expected_readings.pop_front();
        check_field("pixel_average", oldest_reading.pixel_average, out_data.pixel_average);
        check_field("pixel_class", 8'(oldest_reading.pixel_class), 8'(out_data.pixel_class));
        check_field("threshold_out", oldest_reading.threshold_out, out_data.threshold_out);
      end
    end
  end

  // Watchdog: a hang or a lost reading ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left just after a rising edge, so each
  // nonblocking drive lands once per time step.
  // ---------------------------------------------------------------------------

  // One snapshot transfer. in_valid is left high; the next call keeps it high
  // (back to back) or drops it for idle cycles.
  task automatic send_snapshot(input ccpc_pkg::in_t snap);
    ccpc_pkg::out_t reading;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= snap;
    do @(posedge clk); while (!in_ready);
    if (measure_snapshot(snap, reading)) begin
      expected_readings.push_back(reading);
      readings_predicted++;
    end
    snapshots_sent++;
  endtask

  // Hold the pin stream until every predicted reading has been taken, then wait
  // out the settle margin for the output register to empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only with the unit drained. Mid-frame writes are fine:
  // the measurement state is kept and the new value applies at once.
  task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ccpc_pkg::CFG_MODE:     cal_mode  = value[1:0];
      ccpc_pkg::CFG_ROW_SKIP: skip_rows = value;
      ccpc_pkg::CFG_COL_SKIP: skip_cols = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] noisy(input logic [7:0] level);
    return level ^ 8'($urandom_range(3));
  endfunction

  // One pclk pulse with href high: rise on the first half, fall on the second.
  task automatic pclk_pulse(input logic vs, input logic [7:0] px);
    send_snapshot({vs, 1'b1, 1'b1, px});
    send_snapshot({1'b0, 1'b1, 1'b0, px});
  endtask

  // href pulse with no pixel clock activity: one line end.
  task automatic line_pulse();
    send_snapshot({1'b0, 1'b1, 1'b0, 8'h00});
    send_snapshot({1'b0, 1'b0, 1'b0, 8'h00});
  endtask

  // Camera frame: vsync pulse, then `rows` lines. Line hit_row carries
  // hit_pulses pixel clocks, the others zero to two. glitchy adds stray vsync.
  task automatic send_frame(input int rows, input int hit_row, input int hit_pulses,
                            input logic [7:0] level, input bit glitchy);
    int   pulses;
    logic vs;
    repeat ($urandom_range(1, 3))
      send_snapshot({1'b1, 1'b0, 1'($urandom_range(1)), noisy(level)});
    repeat ($urandom_range(1, 2)) send_snapshot({1'b0, 1'b0, 1'b0, noisy(level)});
    for (int r = 0; r < rows; r++) begin
      pulses = (r == hit_row) ? hit_pulses : $urandom_range(0, 2);
      for (int p = 0; p < pulses; p++) begin
        vs = glitchy && ($urandom_range(9) == 0);
        repeat (1 + ($urandom_range(3) == 0)) send_snapshot({vs, 1'b1, 1'b1, noisy(level)});
        repeat (1 + ($urandom_range(3) == 0)) send_snapshot({1'b0, 1'b1, 1'b0, noisy(level)});
      end
      if (pulses == 0) send_snapshot({1'b0, 1'b1, 1'b0, noisy(level)});
      repeat ($urandom_range(1, 2)) send_snapshot({1'b0, 1'b0, 1'b0, noisy(level)});
    end
  endtask

  // Shortest frame with both skips at zero: vsync fall, href high, then one
  // pixel per pclk rise.
  task automatic send_quick_frame(input logic [7:0] px);
    send_snapshot({1'b1, 1'b0, 1'b0, px});
    send_snapshot({1'b0, 1'b0, 1'b0, px});
    send_snapshot({1'b0, 1'b1, 1'b0, px});
    repeat (NUM_SAMPLES) pclk_pulse(1'b0, px);
  endtask

  task automatic shuffle_settings();
    write_reg(ccpc_pkg::CFG_MODE, 10'($urandom_range(3)));
    if ($urandom_range(1)) write_reg(ccpc_pkg::CFG_ROW_SKIP, 10'($urandom_range(3)));
    if ($urandom_range(1)) write_reg(ccpc_pkg::CFG_COL_SKIP, 10'($urandom_range(3)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Starts on the reset skips (88 rows, 72 columns). Each skip is raised to
  // its maximum mid-count, then dropped to zero so the next edge ends it.
  // The mode moves to white calibration once the sampling phase has begun, and
  // full-scale pixels give the largest average.
  task automatic test_skip_limits();
    send_snapshot({1'b1, 1'b0, 1'b0, 8'h00});
    send_snapshot({1'b0, 1'b0, 1'b0, 8'h00});
    repeat (2) line_pulse();
    write_reg(ccpc_pkg::CFG_ROW_SKIP, 10'h3FF);
    line_pulse();
    write_reg(ccpc_pkg::CFG_ROW_SKIP, 10'h000);
    line_pulse();                               // ends the row skip
    send_snapshot({1'b0, 1'b1, 1'b0, 8'h00});   // href high: column skip starts
    pclk_pulse(1'b0, 8'h00);
    write_reg(ccpc_pkg::CFG_COL_SKIP, 10'h3FF);
    pclk_pulse(1'b0, 8'h00);
    write_reg(ccpc_pkg::CFG_COL_SKIP, 10'h000);
    pclk_pulse(1'b0, 8'h00);                    // ends the column skip
    write_reg(ccpc_pkg::CFG_MODE, {8'd0, ccpc_pkg::MODE_WHITE});
    repeat (NUM_SAMPLES) pclk_pulse(1'b0, 8'hFF);
  endtask

  // Black calibration at zero, then a white calibration whose mean rounds
  // down to zero: the following check must report "not calibrated".
  task automatic test_calibration_to_zero();
    write_reg(ccpc_pkg::CFG_MODE, {8'd0, ccpc_pkg::MODE_BLACK});
    send_quick_frame(8'h00);
    write_reg(ccpc_pkg::CFG_MODE, {8'd0, ccpc_pkg::MODE_WHITE});
    send_quick_frame(8'h01);
    write_reg(ccpc_pkg::CFG_MODE, {8'd0, ccpc_pkg::MODE_CHECK});
    send_quick_frame(8'h80);
  endtask

  // Mostly complete frames at random pixel levels under changing settings,
  // with truncated or glitched frames and raw pin noise mixed in.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int budget);
    int unsigned item_goal;
    int unsigned reading_goal;
    int          pick;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    item_goal    = snapshots_sent + budget;
    reading_goal = readings_predicted + 10;
    while (snapshots_sent < item_goal || readings_predicted < reading_goal) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // register writes first wait out every pending reading
        shuffle_settings();
      end else if (pick < 82) begin
        send_frame(skip_rows + 1 + $urandom_range(1), int'(skip_rows),
                   skip_cols + NUM_SAMPLES + $urandom_range(1, 2), 8'($urandom), 1'b0);
      end else if (pick < 94) begin
        send_frame($urandom_range(0, skip_rows + 1), int'(skip_rows),
                   $urandom_range(0, skip_cols + NUM_SAMPLES), 8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(4, 16)) send_snapshot(11'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_skip_limits();
    test_calibration_to_zero();

    test_random_traffic(0, 0, 340);     // full rate both ways
    test_random_traffic(67, 0, 330);    // sparse snapshots
    test_random_traffic(0, 67, 330);    // heavy result backpressure
    test_random_traffic(19, 19, 330);   // light gaps on both sides

    settle();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
